### rtl/ftrs_pkg.sv
// Shared types and constants for the Fenwick tree range-sum block.
`default_nettype none

package ftrs_pkg;

    localparam int POS_W  = 11;
    localparam int DATA_W = 32;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // item accepted: capture payload
        logic walk_rd;      // prefix walk: read node, strip lowest set bit
        logic walk_sub;     // sign of the node read this cycle
        logic load_before;  // start second prefix walk
        logic add_rd;       // add walk: read node
        logic add_wr;       // add walk: write node + delta, climb
        logic clr_wr;       // clearing pass: zero one entry
        logic out_load;     // move total into output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_query;
        logic empty;
        logic add_ok;
        logic pos_zero;
        logic add_last;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/ftrs_ctrl.sv
// Sequencer for clear, add walk and range-sum walks.
`default_nettype none

module ftrs_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ftrs_pkg::sts_t sts,
    output ftrs_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_ADD_RD  = 3'd2;
    localparam logic [2:0] S_ADD_WR  = 3'd3;
    localparam logic [2:0] S_WALK_HI = 3'd4;
    localparam logic [2:0] S_WALK_LO = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.is_query) begin
                        state_next = sts.empty ? S_OUT : S_WALK_HI;
                    end else if (sts.add_ok) begin
                        state_next = S_ADD_RD;
                    end
                end
            end
            S_ADD_RD: begin
                cmd.add_rd = 1'b1;
                state_next = S_ADD_WR;
            end
            S_ADD_WR: begin
                cmd.add_wr = 1'b1;
                state_next = sts.add_last ? S_IDLE : S_ADD_RD;
            end
            S_WALK_HI: begin
                if (sts.pos_zero) begin
                    cmd.load_before = 1'b1;
                    state_next      = S_WALK_LO;
                end else begin
                    cmd.walk_rd = 1'b1;
                end
            end
            S_WALK_LO: begin
                // last read of the walk lands in acc on this edge
                if (sts.pos_zero) begin
                    state_next = S_OUT;
                end else begin
                    cmd.walk_rd  = 1'b1;
                    cmd.walk_sub = 1'b1;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ftrs_dp.sv
// Datapath: node store, walk position, accumulator and output register.
`default_nettype none

module ftrs_dp #(
    parameter int SIZE = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_req_type,
    input  wire logic        [ftrs_pkg::POS_W-1:0]   s_position_low,
    input  wire logic        [ftrs_pkg::POS_W-1:0]   s_position_high,
    input  wire logic signed [ftrs_pkg::DATA_W-1:0]  s_delta,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ftrs_pkg::DATA_W-1:0]       m_range_total,
    input  wire ftrs_pkg::cmd_t                      cmd,
    output ftrs_pkg::sts_t                           sts
);

    localparam int AW  = $clog2(SIZE);
    localparam int NW  = $clog2(SIZE + 1);
    localparam int PW  = ((ftrs_pkg::POS_W > NW) ? ftrs_pkg::POS_W : NW) + 1;
    localparam int DW  = ftrs_pkg::DATA_W;
    localparam logic [PW-1:0] SIZE_P = PW'(SIZE);

    logic [DW-1:0] mem [SIZE];
    logic [DW-1:0] mem_q_reg;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] before_reg;
    logic [DW-1:0] delta_reg;
    logic [DW-1:0] acc_reg;
    logic          walk_vld_reg;
    logic          walk_sub_reg;
    logic [AW-1:0] clr_reg;
    logic          m_valid_reg;
    logic [DW-1:0] m_data_reg;

    logic [PW-1:0] lo_ext;
    logic [PW-1:0] hi_ext;
    logic [PW-1:0] hi_clamp;
    logic [PW-1:0] pos_up;
    logic [PW-1:0] pos_down;
    logic [PW-1:0] pos_m1;
    logic [AW-1:0] node_addr;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          wr_en;
    logic          rd_en;

    assign lo_ext   = PW'(s_position_low);
    assign hi_ext   = PW'(s_position_high);
    assign hi_clamp = (hi_ext > SIZE_P) ? SIZE_P : hi_ext;
    assign pos_m1   = pos_reg - PW'(1);
    assign pos_up   = pos_reg + (pos_reg & (~pos_reg + PW'(1)));
    assign pos_down = pos_reg & pos_m1;
    assign node_addr = pos_m1[AW-1:0];  // node p lives at address p-1

    assign sts.is_query = s_req_type;
    assign sts.empty    = (lo_ext > hi_clamp);
    assign sts.add_ok   = (lo_ext != '0) && (lo_ext <= SIZE_P);
    assign sts.pos_zero = (pos_reg == '0);
    assign sts.add_last = (pos_up > SIZE_P);
    assign sts.clr_last = (clr_reg == AW'(SIZE - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

    assign rd_en   = cmd.walk_rd || cmd.add_rd;
    assign wr_en   = cmd.add_wr || cmd.clr_wr;
    assign wr_addr = cmd.clr_wr ? clr_reg : node_addr;
    assign wr_data = cmd.clr_wr ? '0 : (mem_q_reg + delta_reg);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg <= mem[node_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // position, operand, accumulator and output data registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg    <= s_req_type ? hi_clamp : lo_ext;
            before_reg <= (lo_ext == '0) ? '0 : (lo_ext - PW'(1));
            delta_reg  <= s_delta;
        end else if (cmd.load_before) begin
            pos_reg <= before_reg;
        end else if (cmd.walk_rd) begin
            pos_reg <= pos_down;
        end else if (cmd.add_wr) begin
            pos_reg <= pos_up;
        end
        if (cmd.walk_rd) begin
            walk_sub_reg <= cmd.walk_sub;
        end
        if (cmd.load) begin
            acc_reg <= '0;
        end else if (walk_vld_reg) begin
            acc_reg <= walk_sub_reg ? (acc_reg - mem_q_reg) : (acc_reg + mem_q_reg);
        end
        if (cmd.out_load) begin
            m_data_reg <= acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_vld_reg <= 1'b0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            walk_vld_reg <= cmd.walk_rd;
            if (cmd.clr_wr) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_range_total = m_data_reg;

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while held");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_rd |-> (pos_reg != '0 && pos_reg <= SIZE_P))
        else $error("prefix walk node out of range");

    a_add_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.add_rd || cmd.add_wr) |-> (pos_reg != '0 && pos_reg <= SIZE_P))
        else $error("add walk node out of range");

    a_add_rmw_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_rd |=> cmd.add_wr)
        else $error("add read not followed by write");

endmodule

`default_nettype wire

### rtl/fenwick_tree_range_sum.sv
// Top level of the Fenwick tree range-sum block.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  s_      | s_valid s_ready s_req_type s_position_low     | in
//          | s_position_high s_delta                       |
//  m_      | m_valid m_ready m_range_total                 | out
//
// After reset a clearing pass zeroes the node store, one entry at a time, with s_ready low.
// Add: after the accept, each node climbed is read, then written back plus the delta.
// Query: the prefix chain of the clamped high end is summed, then that of low-1 subtracted.
// One item is worked on at a time; s_ready stays low until it is finished.
// A finished total waits in the output register while the next item is taken;
// a query that finds it still full holds in its last cycle with s_ready low.
`default_nettype none

module fenwick_tree_range_sum #(
    parameter int SIZE = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_req_type,
    input  wire logic        [ftrs_pkg::POS_W-1:0]   s_position_low,
    input  wire logic        [ftrs_pkg::POS_W-1:0]   s_position_high,
    input  wire logic signed [ftrs_pkg::DATA_W-1:0]  s_delta,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ftrs_pkg::DATA_W-1:0]       m_range_total
);

    ftrs_pkg::cmd_t cmd;
    ftrs_pkg::sts_t sts;

    ftrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ftrs_dp #(
        .SIZE (SIZE)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_req_type      (s_req_type),
        .s_position_low  (s_position_low),
        .s_position_high (s_position_high),
        .s_delta         (s_delta),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_range_total   (m_range_total),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

`default_nettype wire
